@@ hdl/simple_risc_instruction_executor_assert.svh @@
// assertion macros for the simple risc instruction executor
`ifndef SIMPLE_RISC_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define SIMPLE_RISC_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RSIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RSIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rsie_pkg.sv @@
// shared types and constants for the simple risc instruction executor
`default_nettype none

package rsie_pkg;

    // instruction opcodes
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_AND   = 4'd4,
        OP_OR    = 4'd5,
        OP_XOR   = 4'd6,
        OP_MOVC  = 4'd7,
        OP_STORE = 4'd8,
        OP_LOAD  = 4'd9,
        OP_BZ    = 4'd10,
        OP_BNZ   = 4'd11,
        OP_JUMP  = 4'd12,
        OP_HALT  = 4'd13
    } op_t;

    localparam int REG_IDX_W = 4;
    localparam int PC_W      = 16;
    localparam int DATA_W    = 32;

    localparam logic [PC_W-1:0] PC_STEP        = 16'd4;
    localparam logic [PC_W-1:0] START_PC_RESET = 16'd4000;

    // configuration register index
    localparam logic CFG_START_PC = 1'b0;

    // execute stage outcome for one instruction
    typedef struct packed {
        logic [PC_W-1:0]      npc;
        logic                 taken;
        logic                 halted;
        logic                 we;
        logic [REG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    val;
        logic                 fault;
        logic                 is_load;
        logic                 mem_en;
        logic                 mem_we;
        logic                 zf;
        logic [DATA_W-1:0]    mem_addr;
    } exec_result_t;

endpackage

`default_nettype wire

@@ hdl/rsie_regfile.sv @@
// register file: synchronous two-port read, one write, valid bits for reset-to-zero
`default_nettype none

module rsie_regfile #(
    parameter int REG_COUNT = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           rd_en,
    input  wire logic [rsie_pkg::REG_IDX_W-1:0] rd_idx_a,
    input  wire logic [rsie_pkg::REG_IDX_W-1:0] rd_idx_b,
    input  wire logic                           wr_en,
    input  wire logic [rsie_pkg::REG_IDX_W-1:0] wr_idx,
    input  wire logic [rsie_pkg::DATA_W-1:0]    wr_data,
    output logic      [rsie_pkg::DATA_W-1:0]    rd_data_a,
    output logic      [rsie_pkg::DATA_W-1:0]    rd_data_b
);
    import rsie_pkg::*;

    localparam int RIDX = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DATA_W-1:0]    rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    data_a_reg;
    logic [DATA_W-1:0]    data_b_reg;
    logic [DATA_W-1:0]    byp_data_reg;
    logic                 a_ok_reg;
    logic                 b_ok_reg;
    logic                 a_byp_reg;
    logic                 b_byp_reg;

    logic [RIDX-1:0] addr_a;
    logic [RIDX-1:0] addr_b;
    logic [RIDX-1:0] addr_w;
    logic            in_range_a;
    logic            in_range_b;

    assign addr_a     = RIDX'(rd_idx_a);
    assign addr_b     = RIDX'(rd_idx_b);
    assign addr_w     = RIDX'(wr_idx);
    assign in_range_a = ({2'b00, rd_idx_a} < 6'(REG_COUNT));
    assign in_range_b = ({2'b00, rd_idx_b} < 6'(REG_COUNT));

    // storage array and raw read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[addr_w] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg   <= rf_mem[addr_a];
            data_b_reg   <= rf_mem[addr_b];
            byp_data_reg <= wr_data;
        end
    end

    // written-since-reset bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr_w] <= 1'b1;
        end
    end

    // read qualifiers, including write-through for a same-edge write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ok_reg  <= 1'b0;
            b_ok_reg  <= 1'b0;
            a_byp_reg <= 1'b0;
            b_byp_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            a_ok_reg  <= in_range_a && valid_reg[addr_a];
            b_ok_reg  <= in_range_b && valid_reg[addr_b];
            a_byp_reg <= wr_en && (wr_idx == rd_idx_a);
            b_byp_reg <= wr_en && (wr_idx == rd_idx_b);
        end
    end

    // read result
    assign rd_data_a = a_byp_reg ? byp_data_reg : (a_ok_reg ? data_a_reg : '0);
    assign rd_data_b = b_byp_reg ? byp_data_reg : (b_ok_reg ? data_b_reg : '0);

endmodule

`default_nettype wire

@@ hdl/rsie_dmem.sv @@
// data memory with registered read and a zero-fill sweep after reset
`default_nettype none

module rsie_dmem #(
    parameter int DATA_WORDS = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              acc_en,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(DATA_WORDS)-1:0]     addr,
    input  wire logic [rsie_pkg::DATA_W-1:0]       wr_data,
    output logic      [rsie_pkg::DATA_W-1:0]       rd_data,
    output logic                                   busy
);
    import rsie_pkg::*;

    localparam int DIDX = $clog2(DATA_WORDS);
    localparam logic [DIDX-1:0] LAST_IDX = DIDX'(DATA_WORDS - 1);

    logic [DATA_W-1:0] mem [DATA_WORDS];
    logic [DATA_W-1:0] rd_data_reg;
    logic [DIDX-1:0]   clr_idx_reg;
    logic              busy_reg;

    // clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end
        else if (busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // memory array
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= '0;
        end
        else if (acc_en && wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (!busy_reg && acc_en && !wr_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

@@ hdl/rsie_exec.sv @@
// execute logic: alu, address check, branch resolution and next pc
`default_nettype none

module rsie_exec #(
    parameter int REG_COUNT  = 16,
    parameter int DATA_WORDS = 4096
) (
    input  wire rsie_pkg::op_t                  op,
    input  wire logic [rsie_pkg::REG_IDX_W-1:0] rd_idx,
    input  wire logic [15:0]                    literal,
    input  wire logic [rsie_pkg::DATA_W-1:0]    opnd_a,
    input  wire logic [rsie_pkg::DATA_W-1:0]    opnd_b,
    input  wire logic [rsie_pkg::PC_W-1:0]      pc,
    input  wire logic                           zf,
    input  wire logic                           halted,
    output rsie_pkg::exec_result_t              res
);
    import rsie_pkg::*;

    logic [DATA_W-1:0] imm;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] diff;
    logic [DATA_W-1:0] prod;
    logic [DATA_W-1:0] addr_st;
    logic [DATA_W-1:0] addr_ld;
    logic              rd_in_range;
    logic              we_raw;

    assign imm         = {{16{literal[15]}}, literal};
    assign sum         = opnd_a + opnd_b;
    assign diff        = opnd_a - opnd_b;
    assign prod        = opnd_a * opnd_b;
    assign addr_st     = opnd_b + imm;
    assign addr_ld     = opnd_a + imm;
    assign rd_in_range = ({2'b00, rd_idx} < 6'(REG_COUNT));

    // decode and execute
    always_comb
    begin
        res          = '0;
        we_raw       = 1'b0;
        res.npc      = pc + PC_STEP;
        res.zf       = 1'b0;
        res.halted   = halted;
        res.idx      = rd_idx;
        if (halted)
        begin
            // ignored after halt: pc and flags hold
            res.npc = pc;
            res.zf  = zf;
        end
        else
        begin
            case (op)
                OP_ADD:
                begin
                    res.val = sum;
                    we_raw  = 1'b1;
                    res.zf  = (sum == '0);
                end
                OP_SUB:
                begin
                    res.val = diff;
                    we_raw  = 1'b1;
                    res.zf  = (diff == '0);
                end
                OP_MUL:
                begin
                    res.val = prod;
                    we_raw  = 1'b1;
                    res.zf  = (prod == '0);
                end
                OP_AND:
                begin
                    res.val = opnd_a & opnd_b;
                    we_raw  = 1'b1;
                end
                OP_OR:
                begin
                    res.val = opnd_a | opnd_b;
                    we_raw  = 1'b1;
                end
                OP_XOR:
                begin
                    res.val = opnd_a ^ opnd_b;
                    we_raw  = 1'b1;
                end
                OP_MOVC:
                begin
                    res.val = imm;
                    we_raw  = 1'b1;
                end
                OP_STORE:
                begin
                    res.mem_addr = addr_st;
                    res.fault    = (addr_st >= 32'(DATA_WORDS));
                    res.mem_en   = !res.fault;
                    res.mem_we   = 1'b1;
                end
                OP_LOAD:
                begin
                    res.mem_addr = addr_ld;
                    res.fault    = (addr_ld >= 32'(DATA_WORDS));
                    res.mem_en   = !res.fault;
                    res.is_load  = 1'b1;
                    we_raw       = 1'b1;
                end
                OP_BZ:
                begin
                    if (zf)
                    begin
                        res.taken = 1'b1;
                        res.npc   = pc + literal;
                    end
                end
                OP_BNZ:
                begin
                    if (!zf)
                    begin
                        res.taken = 1'b1;
                        res.npc   = pc + literal;
                    end
                end
                OP_JUMP:
                begin
                    res.taken = 1'b1;
                    res.npc   = opnd_a[PC_W-1:0] + literal;
                end
                OP_HALT:
                begin
                    res.halted = 1'b1;
                end
                default:
                begin
                    res.val = '0;
                end
            endcase
        end

        // drop writes to registers that do not exist
        res.we = we_raw && rd_in_range;
        if (!res.we)
        begin
            res.val     = '0;
            res.idx     = '0;
            res.is_load = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ hdl/simple_risc_instruction_executor.sv @@
// Simple RISC instruction executor. Each stream transaction on s_* carries one decoded
// instruction (opcode in s_tuser) and produces exactly one result transaction on m_*.
// Instructions flow through a three-stage pipeline (register read, execute with data
// memory access, write back), so one instruction is accepted every clock cycle unless the
// clear sweep or a stall holds it; its result is presented on m_* from an output register
// behind write back. A stall on m_tready freezes the whole pipeline. Register operands are
// forwarded from the write-back stage, so back-to-back dependent instructions, including
// loads, need no gaps. After reset the data memory is cleared one word per cycle, with
// s_tready low until it ends; start_pc is readable and writable over APB at any time.
`default_nettype none

module simple_risc_instruction_executor #(
    parameter int DATA_WORDS = 4096,
    parameter int REG_COUNT  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // instruction stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: dest_reg[3:0], src_reg_a[7:4], src_reg_b[11:8], literal[27:12], zero[31:28]
    input  wire logic [31:0] s_tdata,
    // s_tuser: opcode[3:0]
    input  wire logic [3:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: next_pc[15:0], branch_taken[16], halted[17], reg_write_enable[18],
    //          reg_write_index[22:19], reg_write_value[54:23], address_fault[55]
    output logic [55:0]      m_tdata,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rsie_pkg::*;

    `include "simple_risc_instruction_executor_assert.svh"

    localparam int DIDX = $clog2(DATA_WORDS);

    // handshake and pipeline advance
    logic adv;
    logic accept;
    logic clr_busy;

    // configuration
    logic [PC_W-1:0] start_pc_reg;

    // architectural state
    logic [PC_W-1:0] pc_reg;
    logic            zf_reg;
    logic            halt_reg;

    // execute stage
    logic                 ex_valid_reg;
    op_t                  ex_op_reg;
    logic [REG_IDX_W-1:0] ex_rd_reg;
    logic [REG_IDX_W-1:0] ex_ra_reg;
    logic [REG_IDX_W-1:0] ex_rb_reg;
    logic [15:0]          ex_imm_reg;
    logic [DATA_W-1:0]    rf_a;
    logic [DATA_W-1:0]    rf_b;
    logic [DATA_W-1:0]    opnd_a;
    logic [DATA_W-1:0]    opnd_b;
    exec_result_t         ex_res;

    // write-back stage
    logic                 wb_valid_reg;
    logic [PC_W-1:0]      wb_npc_reg;
    logic                 wb_taken_reg;
    logic                 wb_halted_reg;
    logic                 wb_we_reg;
    logic [REG_IDX_W-1:0] wb_idx_reg;
    logic [DATA_W-1:0]    wb_val_reg;
    logic                 wb_load_reg;
    logic                 wb_fault_reg;
    logic [DATA_W-1:0]    mem_rdata;
    logic [DATA_W-1:0]    wb_value;
    logic                 rf_wr_en;

    // output register
    logic                 out_valid_reg;
    logic [PC_W-1:0]      out_npc_reg;
    logic                 out_taken_reg;
    logic                 out_halted_reg;
    logic                 out_we_reg;
    logic [REG_IDX_W-1:0] out_idx_reg;
    logic [DATA_W-1:0]    out_val_reg;
    logic                 out_fault_reg;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && !clr_busy;
    assign accept   = s_tvalid && s_tready;

    // apb register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_START_PC) ? {16'b0, start_pc_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= START_PC_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == CFG_START_PC))
        begin
            start_pc_reg <= pwdata[PC_W-1:0];
        end
    end

    // register file, read at acceptance
    rsie_regfile #(
        .REG_COUNT (REG_COUNT)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_idx_a  (s_tdata[7:4]),
        .rd_idx_b  (s_tdata[11:8]),
        .wr_en     (rf_wr_en),
        .wr_idx    (wb_idx_reg),
        .wr_data   (wb_value),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    // execute stage capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ex_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_op_reg  <= op_t'(s_tuser);
            ex_rd_reg  <= s_tdata[3:0];
            ex_ra_reg  <= s_tdata[7:4];
            ex_rb_reg  <= s_tdata[11:8];
            ex_imm_reg <= s_tdata[27:12];
        end
    end

    // forward from the write-back stage
    assign opnd_a = (wb_valid_reg && wb_we_reg && (wb_idx_reg == ex_ra_reg)) ? wb_value : rf_a;
    assign opnd_b = (wb_valid_reg && wb_we_reg && (wb_idx_reg == ex_rb_reg)) ? wb_value : rf_b;

    rsie_exec #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WORDS (DATA_WORDS)
    ) u_exec (
        .op      (ex_op_reg),
        .rd_idx  (ex_rd_reg),
        .literal (ex_imm_reg),
        .opnd_a  (opnd_a),
        .opnd_b  (opnd_b),
        .pc      (pc_reg),
        .zf      (zf_reg),
        .halted  (halt_reg),
        .res     (ex_res)
    );

    // data memory, accessed as the instruction leaves execute
    rsie_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .acc_en  (adv && ex_valid_reg && ex_res.mem_en),
        .wr_en   (ex_res.mem_we),
        .addr    (ex_res.mem_addr[DIDX-1:0]),
        .wr_data (opnd_a),
        .rd_data (mem_rdata),
        .busy    (clr_busy)
    );

    // pc, zero flag and halt flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= START_PC_RESET;
            zf_reg   <= 1'b0;
            halt_reg <= 1'b0;
        end
        else if (adv && ex_valid_reg)
        begin
            pc_reg   <= ex_res.npc;
            zf_reg   <= ex_res.zf;
            halt_reg <= ex_res.halted;
        end
    end

    // write-back stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            wb_valid_reg <= ex_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wb_npc_reg    <= ex_res.npc;
            wb_taken_reg  <= ex_res.taken;
            wb_halted_reg <= ex_res.halted;
            wb_we_reg     <= ex_res.we;
            wb_idx_reg    <= ex_res.idx;
            wb_val_reg    <= ex_res.val;
            wb_load_reg   <= ex_res.is_load;
            wb_fault_reg  <= ex_res.fault;
        end
    end

    // load data or alu result; a faulting load writes zero
    assign wb_value = (wb_load_reg && !wb_fault_reg) ? mem_rdata : wb_val_reg;
    assign rf_wr_en = adv && wb_valid_reg && wb_we_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= wb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_npc_reg    <= wb_npc_reg;
            out_taken_reg  <= wb_taken_reg;
            out_halted_reg <= wb_halted_reg;
            out_we_reg     <= wb_we_reg;
            out_idx_reg    <= wb_idx_reg;
            out_val_reg    <= wb_value;
            out_fault_reg  <= wb_fault_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_fault_reg, out_val_reg, out_idx_reg, out_we_reg,
                       out_halted_reg, out_taken_reg, out_npc_reg};

    // checks
    `RSIE_ASSERT_NOW(a_no_accept_clear, clr_busy, !s_tready, "instruction accepted during clear")
    `RSIE_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg, "halt flag dropped without reset")
    `RSIE_ASSERT_NEXT(a_wb_to_out, wb_valid_reg && adv, m_tvalid, "result lost between stages")
    `RSIE_ASSERT_NOW(a_halted_quiet, m_tvalid && out_halted_reg,
                     !(out_we_reg || out_taken_reg || out_fault_reg), "halted result not quiet")

endmodule

`default_nettype wire
